[src/polyline_knot_filter_core_defines.svh]
// ----------------------------------------------------------------------------
// Polyline knot filter assertion macros
// Shared concurrent assertion forms for the knot filter RTL.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_KNOT_FILTER_CORE_DEFINES_SVH
`define POLYLINE_KNOT_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PKF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knot filter check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define PKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knot filter check failed: next-cycle implication");

`endif

[src/pkf_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline knot filter package
// Sequencer states, multiplier operation codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pkf_pkg;

    // Width of one multiplier digit of the B operand
    localparam int DIGIT_BITS   = 16;
    // Width of the spacing register
    localparam int SPACING_BITS = 13;
    // Register index of min_spacing (paddr word bit)
    localparam logic REG_MIN_SPACING = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_POST,
        ST_OUT
    } t_state;

    // One product step of the shared multiplier
    typedef enum logic [3:0] {
        OP_DX2,   // dx^2
        OP_DY2,   // dy^2, summed
        OP_LIM2,  // limit^2 and distance compare
        OP_RXVX,  // rx*vx
        OP_RYVY,  // ry*vy, dot sign test
        OP_RX2,   // rx^2
        OP_RY2,   // ry^2, gives |r|^2
        OP_VX2,   // vx^2
        OP_VY2,   // vy^2, gives |v|^2
        OP_DOT2,  // dot^2
        OP_CMP    // 3|r|^2|v|^2 and turn compare
    } t_op;

endpackage

`default_nettype wire

[src/polyline_knot_filter_core.sv]
// ----------------------------------------------------------------------------
// Polyline knot filter core
// Two chained decimation stages on a contour point stream: minimum spacing,
// then a turn limit of 150 degrees, both tested with exact integer products.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  point in  | i_valid / o_stall  | i_point_x, i_point_y, i_contour_start
//  kept out  | o_valid / i_stall  | o_kept_x, o_kept_y, o_kept_start
//  config    | psel/penable/...   | paddr, pwdata, prdata (min_spacing)
//
//  A contour start skips the product steps: PREP, then OUT.
//  Other points run up to 11 product steps (MUL over ND digits, then POST) on
//  one shared A x 16-bit digit multiplier, ND = ceil((2*COORD_BITS + 2) / 16);
//  a spacing drop or a positive dot test ends the pass after fewer steps.
//  Reset is synchronous, active low; it clears the anchors and the output.
//  The next point is taken while a kept point waits in the output register;
//  a result stalls the sequencer only when that register is still full.
//
`default_nettype none

`include "polyline_knot_filter_core_defines.svh"

module polyline_knot_filter_core #(
    parameter int COORD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // point input channel
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire signed [COORD_BITS-1:0] i_point_x,
    input  wire signed [COORD_BITS-1:0] i_point_y,
    input  wire                         i_contour_start,
    // kept point output channel
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [COORD_BITS-1:0] o_kept_x,
    output logic signed [COORD_BITS-1:0] o_kept_y,
    output logic                        o_kept_start,
    // configuration port
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [2:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int C   = COORD_BITS;
    localparam int D   = pkf_pkg::DIGIT_BITS;
    localparam int SPW = pkf_pkg::SPACING_BITS;
    localparam int DW  = C + 1;             // coordinate difference
    localparam int SQW = 2 * C + 2;         // squared lengths and |dot|
    localparam int SW  = 2 * C + 3;         // signed running sum
    localparam int AW  = 2 * C + 3;         // A operand (3|r|^2)
    localparam int ND  = (SQW + D - 1) / D; // digits of the B operand
    localparam int BP  = ND * D;
    localparam int PW  = 4 * C + 5;         // full product
    localparam int QW  = 4 * C + 3;         // dot^2
    localparam int DCW = (ND > 1) ? $clog2(ND) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    pkf_pkg::t_state r_state, n_state;
    pkf_pkg::t_op    r_op, n_op;
    logic [DCW-1:0]  r_dig, n_dig;
    logic [PW-1:0]   r_p, n_p;
    logic signed [SW-1:0] r_s, n_s;

    logic [SPW-1:0]       r_spacing;
    logic signed [C-1:0]  r_px, r_py;
    logic                 r_start;
    logic signed [C-1:0]  r_dist_x, r_dist_y, r_turn_x, r_turn_y;
    logic signed [DW-1:0] r_ref_x, r_ref_y;
    logic                 r_valid;
    logic                 r_emit_start;

    logic [DW-1:0]        r_dxm, r_dym, r_vxm, r_vym, r_rxm, r_rym;
    logic signed [DW-1:0] r_vx, r_vy;
    logic [SQW-1:0]       r_dotm, r_r2, r_v2;
    logic [AW-1:0]        r_r3;
    logic [QW-1:0]        r_q;

    logic                 r_out_valid;
    logic signed [C-1:0]  r_out_x, r_out_y;
    logic                 r_out_start;

    // ------------------------------------------------------------------
    // Handshake terms
    // ------------------------------------------------------------------
    logic w_in_acc, w_out_free, w_cfg_wr, w_is_start, w_spacing_on;
    assign w_in_acc     = i_valid && !o_stall;
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_cfg_wr     = psel && penable && pwrite && pready;
    assign w_is_start   = r_start || !r_valid;
    assign w_spacing_on = |r_spacing[SPW-1:1];

    // ------------------------------------------------------------------
    // Point preparation: differences and magnitudes
    // ------------------------------------------------------------------
    logic signed [DW-1:0] w_dx, w_dy, w_vx_raw, w_vy_raw, w_vx, w_vy;
    logic [DW-1:0]        w_dxm, w_dym, w_vxm, w_vym, w_rxm, w_rym;
    logic [SPW-1:0]       w_lim;

    always_comb begin
        w_dx     = $signed({r_px[C-1], r_px}) - $signed({r_dist_x[C-1], r_dist_x});
        w_dy     = $signed({r_py[C-1], r_py}) - $signed({r_dist_y[C-1], r_dist_y});
        w_vx_raw = $signed({r_px[C-1], r_px}) - $signed({r_turn_x[C-1], r_turn_x});
        w_vy_raw = $signed({r_py[C-1], r_py}) - $signed({r_turn_y[C-1], r_turn_y});
        // a zero vector bears 0 degrees
        if (w_vx_raw == '0 && w_vy_raw == '0) begin
            w_vx = DW'(1);
            w_vy = '0;
        end else begin
            w_vx = w_vx_raw;
            w_vy = w_vy_raw;
        end
        w_dxm = w_dx[DW-1]    ? DW'(-w_dx)    : w_dx;
        w_dym = w_dy[DW-1]    ? DW'(-w_dy)    : w_dy;
        w_vxm = w_vx[DW-1]    ? DW'(-w_vx)    : w_vx;
        w_vym = w_vy[DW-1]    ? DW'(-w_vy)    : w_vy;
        w_rxm = r_ref_x[DW-1] ? DW'(-r_ref_x) : r_ref_x;
        w_rym = r_ref_y[DW-1] ? DW'(-r_ref_y) : r_ref_y;
        w_lim = r_spacing - SPW'(1);
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select and one digit per cycle
    // ------------------------------------------------------------------
    logic [AW-1:0]   w_a;
    logic [SQW-1:0]  w_b;
    logic [BP-1:0]   w_b_pad;
    logic [D-1:0]    w_digit;
    logic [AW+D-1:0] w_prod;

    always_comb begin
        unique case (r_op)
            pkf_pkg::OP_DX2:  begin w_a = AW'(r_dxm);  w_b = SQW'(r_dxm); end
            pkf_pkg::OP_DY2:  begin w_a = AW'(r_dym);  w_b = SQW'(r_dym); end
            pkf_pkg::OP_LIM2: begin w_a = AW'(w_lim);  w_b = SQW'(w_lim); end
            pkf_pkg::OP_RXVX: begin w_a = AW'(r_rxm);  w_b = SQW'(r_vxm); end
            pkf_pkg::OP_RYVY: begin w_a = AW'(r_rym);  w_b = SQW'(r_vym); end
            pkf_pkg::OP_RX2:  begin w_a = AW'(r_rxm);  w_b = SQW'(r_rxm); end
            pkf_pkg::OP_RY2:  begin w_a = AW'(r_rym);  w_b = SQW'(r_rym); end
            pkf_pkg::OP_VX2:  begin w_a = AW'(r_vxm);  w_b = SQW'(r_vxm); end
            pkf_pkg::OP_VY2:  begin w_a = AW'(r_vym);  w_b = SQW'(r_vym); end
            pkf_pkg::OP_DOT2: begin w_a = AW'(r_dotm); w_b = r_dotm;      end
            pkf_pkg::OP_CMP:  begin w_a = r_r3;        w_b = r_v2;        end
            default:          begin w_a = '0;          w_b = '0;          end
        endcase
        w_b_pad = BP'(w_b);
        w_digit = w_b_pad[r_dig*D +: D];
        w_prod  = w_a * w_digit;
    end

    // ------------------------------------------------------------------
    // Step results: sums, decisions and the next step
    // ------------------------------------------------------------------
    logic signed [SW-1:0] w_p_s, w_sum, w_dot;
    logic                 w_neg_x, w_neg_y;
    logic                 w_post_drop, w_post_keep;
    pkf_pkg::t_op         w_next_op;

    always_comb begin
        w_p_s   = SW'(r_p);
        w_sum   = r_s + w_p_s;
        w_neg_x = r_ref_x[DW-1] ^ r_vx[DW-1];
        w_neg_y = r_ref_y[DW-1] ^ r_vy[DW-1];
        w_dot   = w_neg_y ? (r_s - w_p_s) : w_sum;
        w_post_drop = 1'b0;
        w_post_keep = 1'b0;
        w_next_op   = pkf_pkg::OP_DX2;
        unique case (r_op)
            pkf_pkg::OP_DX2:  w_next_op = pkf_pkg::OP_DY2;
            pkf_pkg::OP_DY2:  w_next_op = pkf_pkg::OP_LIM2;
            pkf_pkg::OP_LIM2: begin
                w_post_drop = ({{(PW-SW){1'b0}}, r_s} < r_p);
                w_next_op   = pkf_pkg::OP_RXVX;
            end
            pkf_pkg::OP_RXVX: w_next_op = pkf_pkg::OP_RYVY;
            pkf_pkg::OP_RYVY: begin
                w_post_keep = !w_dot[SW-1];
                w_next_op   = pkf_pkg::OP_RX2;
            end
            pkf_pkg::OP_RX2:  w_next_op = pkf_pkg::OP_RY2;
            pkf_pkg::OP_RY2:  w_next_op = pkf_pkg::OP_VX2;
            pkf_pkg::OP_VX2:  w_next_op = pkf_pkg::OP_VY2;
            pkf_pkg::OP_VY2:  w_next_op = pkf_pkg::OP_DOT2;
            pkf_pkg::OP_DOT2: w_next_op = pkf_pkg::OP_CMP;
            pkf_pkg::OP_CMP: begin
                w_post_drop = ({r_q, 2'b00} > r_p);
                w_post_keep = !w_post_drop;
            end
            default: w_post_drop = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkf_pkg::ST_IDLE: if (w_in_acc) n_state = pkf_pkg::ST_PREP;
            pkf_pkg::ST_PREP: n_state = w_is_start ? pkf_pkg::ST_OUT : pkf_pkg::ST_MUL;
            pkf_pkg::ST_MUL:  if (r_dig == '0) n_state = pkf_pkg::ST_POST;
            pkf_pkg::ST_POST: begin
                if (w_post_drop) begin
                    n_state = pkf_pkg::ST_IDLE;
                end else if (w_post_keep) begin
                    n_state = pkf_pkg::ST_OUT;
                end else begin
                    n_state = pkf_pkg::ST_MUL;
                end
            end
            pkf_pkg::ST_OUT:  if (w_out_free) n_state = pkf_pkg::ST_IDLE;
            default:          n_state = pkf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall      = (r_state != pkf_pkg::ST_IDLE);
        o_valid      = r_out_valid;
        o_kept_x     = r_out_x;
        o_kept_y     = r_out_y;
        o_kept_start = r_out_start;
        pready       = 1'b1;
        prdata       = (paddr[2] == pkf_pkg::REG_MIN_SPACING) ? 32'(r_spacing) : 32'd0;
    end

    // ------------------------------------------------------------------
    // Sequencer and multiplier datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_op  = r_op;
        n_dig = r_dig;
        n_p   = r_p;
        n_s   = r_s;
        unique case (r_state)
            pkf_pkg::ST_PREP: begin
                n_op  = w_spacing_on ? pkf_pkg::OP_DX2 : pkf_pkg::OP_RXVX;
                n_dig = DCW'(ND - 1);
            end
            pkf_pkg::ST_MUL: begin
                // accumulate digits from the top down
                n_p   = ((r_dig == DCW'(ND - 1)) ? PW'(0) : (r_p << D)) + PW'(w_prod);
                n_dig = r_dig - DCW'(1);
            end
            pkf_pkg::ST_POST: begin
                n_op  = w_next_op;
                n_dig = DCW'(ND - 1);
                case (r_op)
                    pkf_pkg::OP_DX2:  n_s = w_p_s;
                    pkf_pkg::OP_DY2:  n_s = w_sum;
                    pkf_pkg::OP_RXVX: n_s = w_neg_x ? -w_p_s : w_p_s;
                    pkf_pkg::OP_RYVY: n_s = w_dot;
                    pkf_pkg::OP_RX2:  n_s = w_p_s;
                    pkf_pkg::OP_VX2:  n_s = w_p_s;
                    default:          n_s = r_s;
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pkf_pkg::ST_IDLE;
            r_op        <= pkf_pkg::OP_DX2;
            r_dig       <= '0;
            r_spacing   <= '0;
            r_valid     <= 1'b0;
            r_dist_x    <= '0;
            r_dist_y    <= '0;
            r_turn_x    <= '0;
            r_turn_y    <= '0;
            r_ref_x     <= DW'(1);
            r_ref_y     <= -DW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_dig   <= n_dig;
            // take a configuration write
            if (w_cfg_wr && paddr[2] == pkf_pkg::REG_MIN_SPACING) begin
                r_spacing <= pwdata[SPW-1:0];
            end
            // restart both anchors on a contour start
            if (r_state == pkf_pkg::ST_PREP && w_is_start) begin
                r_valid  <= 1'b1;
                r_dist_x <= r_px;
                r_dist_y <= r_py;
                r_turn_x <= r_px;
                r_turn_y <= r_py;
                r_ref_x  <= DW'(1);
                r_ref_y  <= -DW'(1);
            end
            // advance the spacing anchor when stage one keeps the point
            if ((r_state == pkf_pkg::ST_PREP && !w_is_start && !w_spacing_on) ||
                (r_state == pkf_pkg::ST_POST && r_op == pkf_pkg::OP_LIM2 && !w_post_drop)) begin
                r_dist_x <= r_px;
                r_dist_y <= r_py;
            end
            // advance the turn anchor and direction when stage two keeps it
            if (r_state == pkf_pkg::ST_POST && w_post_keep) begin
                r_turn_x <= r_px;
                r_turn_y <= r_py;
                r_ref_x  <= r_vx;
                r_ref_y  <= r_vy;
            end
            // output register: load a kept point, drop it once taken
            if (r_state == pkf_pkg::ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_s <= n_s;
        // capture the point transaction
        if (w_in_acc) begin
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_start <= i_contour_start;
        end
        // hold magnitudes and signs for the product steps
        if (r_state == pkf_pkg::ST_PREP) begin
            r_emit_start <= w_is_start;
            r_dxm        <= w_dxm;
            r_dym        <= w_dym;
            r_vx         <= w_vx;
            r_vy         <= w_vy;
            r_vxm        <= w_vxm;
            r_vym        <= w_vym;
            r_rxm        <= w_rxm;
            r_rym        <= w_rym;
        end
        // store intermediate products of the turn test
        if (r_state == pkf_pkg::ST_POST) begin
            case (r_op)
                pkf_pkg::OP_RX2:  r_dotm <= SQW'(-r_s);
                pkf_pkg::OP_RY2:  r_r2   <= SQW'(w_sum);
                pkf_pkg::OP_VX2:  r_r3   <= {1'b0, r_r2} + {r_r2, 1'b0};
                pkf_pkg::OP_VY2:  r_v2   <= SQW'(w_sum);
                pkf_pkg::OP_DOT2: r_q    <= QW'(r_p);
                default: ;
            endcase
        end
        if (r_state == pkf_pkg::ST_OUT && w_out_free) begin
            r_out_x     <= r_px;
            r_out_y     <= r_py;
            r_out_start <= r_emit_start;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PKF_ASSERT_NEXT(a_accept_preps, i_clk, i_rst_n, w_in_acc, r_state == pkf_pkg::ST_PREP)
    `PKF_ASSERT_NEXT(a_last_digit_posts, i_clk, i_rst_n,
        (r_state == pkf_pkg::ST_MUL && r_dig == '0), r_state == pkf_pkg::ST_POST)
    `PKF_ASSERT_HOLDS(a_output_needs_anchor, i_clk, i_rst_n, r_out_valid, r_valid)
    `PKF_ASSERT_HOLDS(a_ref_dir_nonzero, i_clk, i_rst_n, r_valid,
        (r_ref_x != '0 || r_ref_y != '0))

endmodule

`default_nettype wire

[tb/tb_polyline_knot_filter_core.sv]
// ----------------------------------------------------------------------------
// Polyline knot filter core testbench
// Streams contour points through the filter under random sender gaps and
// receiver stalls. A scoreboard predicts every kept point from its own copy
// of the spacing and turn-limit stages and checks each output transaction.
// ----------------------------------------------------------------------------

module tb_polyline_knot_filter_core;

    localparam int CB            = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Allow margin for the longest sequencer pass before reconfiguring
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_POINTS  = 168;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic signed [CB:0]   t_dir;
    typedef logic [pkf_pkg::SPACING_BITS-1:0] t_spacing;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   start;
    } t_kept_point;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_RUNS
    } t_rx_pattern;

    // ------------------------------------------------------------------------
    // Scoreboard: spacing stage, turn stage and the queue of kept points
    // ------------------------------------------------------------------------
    class t_kept_point_board;
        t_kept_point kept_q[$];
        t_coord      space_ax, space_ay;
        t_coord      turn_ax, turn_ay;
        t_dir        dir_x, dir_y;
        bit          anchored;
        t_spacing    spacing;
        int          errors, matched, dropped, contours;

        function new();
            space_ax = '0;
            space_ay = '0;
            turn_ax  = '0;
            turn_ay  = '0;
            dir_x    = t_dir'(1);
            dir_y    = t_dir'(-1);
            anchored = 1'b0;
            spacing  = '0;
        endfunction

        function void set_spacing(int value);
            spacing = t_spacing'(value);
        endfunction

        function int pending();
            return kept_q.size();
        endfunction

        // Run one accepted point through both stages
        function void note_point(t_coord px, t_coord py, logic start_in);
            longint      dx, dy, vx, vy, lim, dot, r2, v2;
            logic [127:0] lhs, rhs;
            t_kept_point kp;
            kp.x = px;
            kp.y = py;
            kp.start = 1'b0;
            // Contour start or no contour yet: re-anchor both stages
            if (start_in || !anchored) begin
                space_ax = px;
                space_ay = py;
                turn_ax  = px;
                turn_ay  = py;
                dir_x    = t_dir'(1);
                dir_y    = t_dir'(-1);
                anchored = 1'b1;
                kp.start = 1'b1;
                contours++;
                kept_q.push_back(kp);
                return;
            end
            // Spacing stage: drop points closer than spacing minus one
            if (spacing >= 2) begin
                lim = longint'(spacing) - 1;
                dx  = longint'(px) - longint'(space_ax);
                dy  = longint'(py) - longint'(space_ay);
                if (dx * dx + dy * dy < lim * lim) begin
                    dropped++;
                    return;
                end
            end
            space_ax = px;
            space_ay = py;
            // Turn stage: a zero vector bears 0 degrees
            vx = longint'(px) - longint'(turn_ax);
            vy = longint'(py) - longint'(turn_ay);
            if (vx == 0 && vy == 0)
                vx = 1;
            dot = longint'(dir_x) * vx + longint'(dir_y) * vy;
            if (dot < 0) begin
                r2  = longint'(dir_x) * longint'(dir_x) + longint'(dir_y) * longint'(dir_y);
                v2  = vx * vx + vy * vy;
                lhs = 128'(-dot);
                lhs = lhs * lhs * 4;
                rhs = 128'(r2) * 128'(v2) * 3;
                // Strictly more than 150 degrees
                if (lhs > rhs) begin
                    dropped++;
                    return;
                end
            end
            dir_x   = t_dir'(vx);
            dir_y   = t_dir'(vy);
            turn_ax = px;
            turn_ay = py;
            kept_q.push_back(kp);
        endfunction

        // Compare one output transaction with the oldest kept point
        function void check_kept(t_coord x, t_coord y, logic start_out);
            t_kept_point want;
            if (kept_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected kept point (%0d, %0d) start %0b", $time,
                         x, y, start_out);
                return;
            end
            want = kept_q.pop_front();
            if (x !== want.x) begin
                errors++;
                $display("%0t: kept_x mismatch: expected %0d, actual %0d", $time, want.x, x);
            end
            if (y !== want.y) begin
                errors++;
                $display("%0t: kept_y mismatch: expected %0d, actual %0d", $time, want.y, y);
            end
            if (start_out !== want.start) begin
                errors++;
                $display("%0t: kept_start mismatch: expected %0b, actual %0b", $time,
                         want.start, start_out);
            end
            matched++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_coord      i_point_x = '0;
    t_coord      i_point_y = '0;
    logic        i_contour_start = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_coord      o_kept_x;
    t_coord      o_kept_y;
    logic        o_kept_start;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_kept_point_board board = new();
    int          cycle_count = 0;
    int          burst_left = 0;
    int          sent = 0;
    int          settings = 0;
    t_rx_pattern rx_pattern = RX_FREE;
    int          rx_left = 0;

    polyline_knot_filter_core #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_contour_start(i_contour_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kept_x       (o_kept_x),
        .o_kept_y       (o_kept_y),
        .o_kept_start   (o_kept_start),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock and cycle count
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver stall pattern: switch between free, light, heavy and long runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_left <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
                rx_left    <= $urandom_range(40, 400);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_pattern)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:  i_stall <= ($urandom_range(0, 15) == 0) ? !i_stall : i_stall;
            endcase
        end
    end

    // Sample both channels; check outputs before noting new inputs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_kept(o_kept_x, o_kept_y, o_kept_start);
            if (i_valid && !o_stall)
                board.note_point(i_point_x, i_point_y, i_contour_start);
        end
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** polyline_knot_filter_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one point and hold it until the transaction completes
    task automatic push_point(input int x, input int y, input bit s);
        i_valid         <= 1'b1;
        i_point_x       <= t_coord'(x);
        i_point_y       <= t_coord'(y);
        i_contour_start <= s;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // End of burst: drop valid for a random gap, then pick the next burst
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold off input until every kept point is out and the sequencer is quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write min_spacing: setup cycle, then access cycle until ready
    task automatic write_spacing(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pkf_pkg::REG_MIN_SPACING, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_spacing(value);
        settings++;
    endtask

    // Random step: tiny, around the spacing, medium or huge, either sign
    function automatic int random_step();
        int span;
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(0, 6);
            1:       span = $urandom_range(0, int'(board.spacing) * 3 / 2 + 4);
            2:       span = $urandom_range(0, 3000);
            default: span = $urandom_range(0, 40000);
        endcase
        return ($urandom_range(0, 1) == 1) ? -span : span;
    endfunction

    // Random contours: mostly walks with reversals, plus repeats and noise
    task automatic run_walk(input int count);
        t_coord cx, cy;
        int     sx, sy, pick;
        bit     s;
        cx = t_coord'($urandom);
        cy = t_coord'($urandom);
        sx = 0;
        sy = 0;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            s    = 1'b0;
            if (k == 0 || pick < 5) begin
                cx = t_coord'($urandom);
                cy = t_coord'($urandom);
                sx = random_step();
                sy = random_step();
                s  = 1'b1;
            end else if (pick < 13) begin
                cx = t_coord'($urandom);
                cy = t_coord'($urandom);
                s  = ($urandom_range(0, 3) == 0);
            end else if (pick < 21) begin
                // repeat the last point
            end else if (pick < 31) begin
                // turn back with a little jitter
                sx = -sx + int'($urandom_range(0, 6)) - 3;
                sy = -sy + int'($urandom_range(0, 6)) - 3;
                cx = cx + t_coord'(sx);
                cy = cy + t_coord'(sy);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    sx = random_step();
                    sy = random_step();
                end
                cx = cx + t_coord'(sx);
                cy = cy + t_coord'(sy);
            end
            push_point(int'(cx), int'(cy), s);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int spacing_plan[11];
        spacing_plan = '{0, 4095, 1, 3, 4096, 12, 2, 250, 1500, 40, 0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Spacing 0: first point with no contour, zero vectors, turn limits
        push_point(0, 0, 1'b0);
        push_point(32767, 32767, 1'b0);
        push_point(32767, 32767, 1'b0);
        push_point(-32768, -32768, 1'b1);
        push_point(-32768, -32768, 1'b0);
        push_point(0, 0, 1'b1);
        push_point(0, 0, 1'b0);
        push_point(-26, 15, 1'b0);
        push_point(-97, 56, 1'b0);
        push_point(-45, 26, 1'b0);
        push_point(0, 0, 1'b0);
        // Full-range reversal needs the wide product
        push_point(-32768, 32767, 1'b1);
        push_point(32767, -32768, 1'b0);
        push_point(-32768, 32767, 1'b0);
        settle();

        // Largest spacing: boundary distance and anchor advance on turn drop
        write_spacing(4096);
        push_point(0, 0, 1'b1);
        push_point(4094, 0, 1'b0);
        push_point(4095, 0, 1'b0);
        push_point(0, 0, 1'b0);
        push_point(100, 0, 1'b0);
        settle();

        // Spacing 2 drops only repeats; spacing 1 drops nothing
        write_spacing(2);
        push_point(5, 5, 1'b1);
        push_point(5, 5, 1'b0);
        push_point(6, 5, 1'b0);
        settle();
        write_spacing(1);
        push_point(7, 7, 1'b1);
        push_point(7, 7, 1'b0);
        settle();

        // Random phases over a spread of spacings
        foreach (spacing_plan[p]) begin
            write_spacing(spacing_plan[p]);
            run_walk(PHASE_POINTS);
            settle();
        end

        $display("Run covered %0d points in %0d contours over %0d spacing settings (0 to 4096).",
                 sent, board.contours, settings);
        $display("%0d kept points checked, %0d points dropped, %0d mismatches.",
                 board.matched, board.dropped, board.errors);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** polyline_knot_filter_core: PASSED **");
        end else begin
            $display("** polyline_knot_filter_core: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/pkf_pkg.sv
src/polyline_knot_filter_core.sv
tb/tb_polyline_knot_filter_core.sv
